### rtl/msbq_pkg.sv
// ----------------------------------------------------------------------------
// msbq_pkg
// Shared types and constants of the multilevel bounce-queue scheduler.
// ----------------------------------------------------------------------------
package msbq_pkg;

	localparam int LEVELS_DEF      = 4;
	localparam int LEVEL_DEPTH_DEF = 16;
	localparam int ID_BITS_DEF     = 8;

	localparam logic [15:0] QUANTUM_RST = 16'd1000;

	localparam logic [1:0] KIND_SUBMIT = 2'd0;
	localparam logic [1:0] KIND_TICK   = 2'd1;
	localparam logic [1:0] KIND_FINISH = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] job_id;
		logic [1:0] level;
	} evt_t;

	typedef struct packed {
		logic       dispatched;
		logic [7:0] run_job;
		logic [1:0] run_level;
		logic       resumed;
		logic       stopped;
		logic [7:0] stopped_job;
		logic       finish_matched;
		logic       overflow;
		logic       idle;
	} res_t;

endpackage

### rtl/msbq_ram.sv
// ----------------------------------------------------------------------------
// msbq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module msbq_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/multilevel_bounce_queue_scheduler_top.sv
// ----------------------------------------------------------------------------
// multilevel_bounce_queue_scheduler_top
// Multilevel feedback scheduler with bouncing levels and lazy head cleanup.
// ----------------------------------------------------------------------------
// One event is handled at a time by a small sequencer around a single entry
// RAM (one read and one write port, registered read). Anything that may
// dispatch runs a cleanup pass over the queue heads: an empty level is
// skipped, a non-empty level has its head read and checked, finished heads
// are popped, and then the chosen job is read and started. A finish that
// misses the running job scans queues head to tail, level by level, over at
// most LEVELS*LEVEL_DEPTH entries. The next event is taken once the previous
// result beat is registered; evt_stall is high while an event is in progress.
module multilevel_bounce_queue_scheduler_top #(
	parameter int LEVELS      = msbq_pkg::LEVELS_DEF,
	parameter int LEVEL_DEPTH = msbq_pkg::LEVEL_DEPTH_DEF,
	parameter int ID_BITS     = msbq_pkg::ID_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             evt_valid,
	output logic             evt_stall,
	input  msbq_pkg::evt_t   evt,
	output logic             res_valid,
	input  logic             res_stall,
	output msbq_pkg::res_t   res,
	input  logic             cfg_we,
	input  logic [15:0]      cfg_data
);

	localparam int LVL_W  = $clog2(LEVELS);
	localparam int PTR_W  = $clog2(LEVEL_DEPTH);
	localparam int FILL_W = $clog2(LEVEL_DEPTH + 1);
	localparam int ENT_W  = ID_BITS + 4;
	localparam int RAM_D  = LEVELS * LEVEL_DEPTH;
	localparam int ADDR_W = $clog2(RAM_D);

	typedef enum logic [3:0] {
		S_IDLE, S_SUB, S_EXP_RD, S_EXP_CK, S_EXP_PUSH, S_FIN_RD, S_FIN_CK,
		S_SR_RD, S_SR_CK, S_CL_RD, S_CL_CK, S_SEL, S_DSP_RD, S_DSP_CK, S_DONE
	} state_t;

	state_t state_q;

	logic [PTR_W-1:0]  head_q [LEVELS];
	logic [PTR_W-1:0]  tail_q [LEVELS];
	logic [FILL_W-1:0] fill_q [LEVELS];

	logic               running_q;
	logic [LVL_W-1:0]   run_lv_q;
	logic [ID_BITS-1:0] run_id_q;
	logic [15:0]        ticks_q;
	logic [15:0]        quantum_q;

	logic [ID_BITS-1:0] id_q;
	logic [LVL_W-1:0]   lv_q;
	logic [PTR_W-1:0]   p_q;
	logic [FILL_W-1:0]  n_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [ENT_W-1:0]   ent_q;
	msbq_pkg::res_t     acc_q;
	msbq_pkg::res_t     res_q;
	msbq_pkg::res_t     res_next;
	logic               res_valid_q;

	// entry RAM
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [ENT_W-1:0]  ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [ENT_W-1:0]  ram_rdata;

	msbq_ram #(
		.WIDTH(ENT_W),
		.DEPTH(RAM_D)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// entry fields: {id, started, descending, second, finished}
	logic [ID_BITS-1:0] rd_id;
	logic rd_started, rd_desc, rd_second, rd_fin;
	assign rd_id      = ram_rdata[ENT_W-1:4];
	assign rd_started = ram_rdata[3];
	assign rd_desc    = ram_rdata[2];
	assign rd_second  = ram_rdata[1];
	assign rd_fin     = ram_rdata[0];

	logic [ID_BITS-1:0] id_in;
	logic [LVL_W-1:0]   lvl_in;
	assign id_in  = ID_BITS'(evt.job_id);
	assign lvl_in = (32'(evt.level) >= LEVELS) ? LVL_W'(LEVELS - 1) : LVL_W'(evt.level);

	logic [PTR_W-1:0]  head_cur, tail_cur, ptr_cur;
	logic [FILL_W-1:0] fill_cur;
	logic              full_cur, last_lv;
	assign head_cur = head_q[lv_q];
	assign tail_cur = tail_q[lv_q];
	assign fill_cur = fill_q[lv_q];
	assign full_cur = (fill_cur == FILL_W'(LEVEL_DEPTH));
	assign last_lv  = (lv_q == LVL_W'(LEVELS - 1));
	assign ptr_cur  = (n_q == '0) ? head_cur : p_q;

	function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [ADDR_W-1:0] addr_of(input logic [LVL_W-1:0] lv,
			input logic [PTR_W-1:0] p);
		return ADDR_W'(int'(lv) * LEVEL_DEPTH + int'(p));
	endfunction

	// first non-empty level
	logic [LVL_W-1:0] pick;
	logic             pick_any;
	always_comb begin
		pick     = '0;
		pick_any = 1'b0;
		for (int i = LEVELS - 1; i >= 0; i--) begin
			if (fill_q[i] != '0) begin
				pick     = LVL_W'(i);
				pick_any = 1'b1;
			end
		end
	end

	// expiry: requeue target and updated entry
	logic [LVL_W-1:0] exp_dst;
	logic [ENT_W-1:0] exp_ent;
	logic             exp_up, exp_desc;
	always_comb begin
		exp_dst  = lv_q;
		exp_up   = !rd_desc;
		exp_desc = rd_desc;
		if (!rd_second) begin
			exp_ent = {rd_id, rd_started, rd_desc, 1'b1, rd_fin};
		end else begin
			if (lv_q == '0 || last_lv) begin
				exp_desc = !rd_desc;
				exp_up   = rd_desc;
			end
			if (exp_up) begin
				if (!last_lv) exp_dst = lv_q + 1'b1;
			end else begin
				if (lv_q != '0) exp_dst = lv_q - 1'b1;
			end
			exp_ent = {rd_id, rd_started, exp_desc, 1'b0, rd_fin};
		end
	end

	logic rd_hit;
	assign rd_hit = (rd_id == id_q) && !rd_fin;

	always_comb begin
		res_next      = acc_q;
		res_next.idle = !running_q;
	end

	always_comb begin
		ram_raddr = addr_of(lv_q, (state_q == S_SR_RD) ? ptr_cur : head_cur);
		ram_we    = 1'b0;
		ram_waddr = addr_of(lv_q, tail_cur);
		ram_wdata = {id_q, 4'b0000};
		case (state_q)
			S_SUB: begin
				ram_we = !full_cur;
			end
			S_EXP_PUSH: begin
				ram_we    = !full_cur;
				ram_wdata = ent_q;
			end
			S_FIN_CK, S_SR_CK: begin
				ram_we    = rd_hit;
				ram_waddr = addr_q;
				ram_wdata = {rd_id, rd_started, rd_desc, rd_second, 1'b1};
			end
			S_DSP_CK: begin
				ram_we    = !rd_started;
				ram_waddr = addr_q;
				ram_wdata = {rd_id, 1'b1, (lv_q == '0), 1'b0, 1'b0};
			end
			default: begin
			end
		endcase
	end

	assign evt_stall = (state_q != S_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			running_q   <= 1'b0;
			run_lv_q    <= '0;
			run_id_q    <= '0;
			ticks_q     <= '0;
			quantum_q   <= msbq_pkg::QUANTUM_RST;
			id_q        <= '0;
			lv_q        <= '0;
			p_q         <= '0;
			n_q         <= '0;
			addr_q      <= '0;
			ent_q       <= '0;
			acc_q       <= '0;
			res_q       <= '0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < LEVELS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				fill_q[i] <= '0;
			end
		end else begin
			if (cfg_we) quantum_q <= cfg_data;
			if (state_q == S_DONE && (!res_valid_q || !res_stall)) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			addr_q <= ram_raddr;

			case (state_q)
				S_IDLE: begin
					if (evt_valid) begin
						id_q   <= id_in;
						acc_q  <= '0;
						n_q    <= '0;
						case (evt.kind)
							msbq_pkg::KIND_SUBMIT: begin
								lv_q    <= lvl_in;
								state_q <= S_SUB;
							end
							msbq_pkg::KIND_TICK: begin
								lv_q <= run_lv_q;
								if (!running_q) begin
									state_q <= S_DONE;
								end else if (ticks_q <= 16'd1) begin
									state_q <= S_EXP_RD;
								end else begin
									ticks_q <= ticks_q - 16'd1;
									state_q <= S_DONE;
								end
							end
							msbq_pkg::KIND_FINISH: begin
								if (running_q) begin
									lv_q    <= run_lv_q;
									state_q <= S_FIN_RD;
								end else begin
									lv_q    <= '0;
									state_q <= S_SR_RD;
								end
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_SUB: begin
					if (full_cur) begin
						acc_q.overflow <= 1'b1;
					end else begin
						tail_q[lv_q] <= wrap_next(tail_cur);
						fill_q[lv_q] <= fill_cur + 1'b1;
					end
					lv_q    <= '0;
					state_q <= running_q ? S_DONE : S_CL_RD;
				end
				S_EXP_RD: state_q <= S_EXP_CK;
				S_EXP_CK: begin
					// running job is the head of its level: pop, then requeue
					if (fill_cur != '0) begin
						head_q[lv_q] <= wrap_next(head_cur);
						fill_q[lv_q] <= fill_cur - 1'b1;
					end
					ent_q             <= exp_ent;
					lv_q              <= exp_dst;
					acc_q.stopped     <= 1'b1;
					acc_q.stopped_job <= 8'(run_id_q);
					running_q         <= 1'b0;
					state_q           <= S_EXP_PUSH;
				end
				S_EXP_PUSH: begin
					if (full_cur) begin
						acc_q.overflow <= 1'b1;
					end else begin
						tail_q[lv_q] <= wrap_next(tail_cur);
						fill_q[lv_q] <= fill_cur + 1'b1;
					end
					lv_q    <= '0;
					state_q <= S_CL_RD;
				end
				S_FIN_RD: state_q <= (fill_cur != '0) ? S_FIN_CK : S_SR_RD;
				S_FIN_CK: begin
					lv_q <= '0;
					if (rd_hit) begin
						acc_q.finish_matched <= 1'b1;
						running_q            <= 1'b0;
						state_q              <= S_CL_RD;
					end else begin
						state_q <= S_SR_RD;
					end
				end
				S_SR_RD: begin
					if (n_q >= fill_cur) begin
						n_q <= '0;
						if (last_lv) begin
							state_q <= S_DONE;
						end else begin
							lv_q <= lv_q + 1'b1;
						end
					end else begin
						p_q     <= wrap_next(ptr_cur);
						state_q <= S_SR_CK;
					end
				end
				S_SR_CK: begin
					if (rd_hit) begin
						acc_q.finish_matched <= 1'b1;
						state_q              <= S_DONE;
					end else begin
						n_q     <= n_q + 1'b1;
						state_q <= S_SR_RD;
					end
				end
				S_CL_RD: begin
					if (fill_cur != '0) begin
						state_q <= S_CL_CK;
					end else if (last_lv) begin
						state_q <= S_SEL;
					end else begin
						lv_q <= lv_q + 1'b1;
					end
				end
				S_CL_CK: begin
					// lazy removal of finished heads
					if (rd_fin) begin
						head_q[lv_q] <= wrap_next(head_cur);
						fill_q[lv_q] <= fill_cur - 1'b1;
						state_q      <= S_CL_RD;
					end else if (last_lv) begin
						state_q <= S_SEL;
					end else begin
						lv_q    <= lv_q + 1'b1;
						state_q <= S_CL_RD;
					end
				end
				S_SEL: begin
					lv_q    <= pick;
					state_q <= pick_any ? S_DSP_RD : S_DONE;
				end
				S_DSP_RD: state_q <= S_DSP_CK;
				S_DSP_CK: begin
					running_q        <= 1'b1;
					run_lv_q         <= lv_q;
					run_id_q         <= rd_id;
					ticks_q          <= quantum_q;
					acc_q.dispatched <= 1'b1;
					acc_q.run_job    <= 8'(rd_id);
					acc_q.run_level  <= 2'(lv_q);
					acc_q.resumed    <= rd_started;
					state_q          <= S_DONE;
				end
				S_DONE: begin
					if (!res_valid_q || !res_stall) begin
						res_q   <= res_next;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
